// File: hw/rtl/aescbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 CBC package
// Types, register indexes and byte-level AES functions shared by the core.
// ----------------------------------------------------------------------------
package aescbc_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 64;

   localparam logic [CsrIndexWidth-1:0] CSR_KEY_HIGH  = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_KEY_LOW   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_IV_HIGH   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_IV_LOW    = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_DIRECTION = 3'd4;

   // Substitution tables, entry 0 in the most significant byte.
   localparam logic [2047:0] SBOX_FWD_BITS = {
      128'h637c777bf26b6fc53001672bfed7ab76,
      128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115,
      128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84,
      128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8,
      128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973,
      128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479,
      128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
      128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df,
      128'h8ca1890dbfe6426841992d0fb054bb16
   };

   localparam logic [2047:0] SBOX_INV_BITS = {
      128'h52096ad53036a538bf40a39e81f3d7fb,
      128'h7ce339829b2fff87348e4344c4dee9cb,
      128'h547b9432a6c2233dee4c950b42fac34e,
      128'h082ea16628d924b2765ba2496d8bd125,
      128'h72f8f66486689816d4a45ccc5d65b692,
      128'h6c704850fdedb9da5e154657a78d9d84,
      128'h90d8ab008cbcd30af7e45805b8b34506,
      128'hd02c1e8fca3f0f02c1afbd0301138a6b,
      128'h3a9111414f67dcea97f2cfcef0b4e673,
      128'h96ac7422e7ad3585e2f937e81c75df6e,
      128'h47f11a711d29c5896fb7620eaa18be1b,
      128'hfc563e4bc6d279209adbc0fe78cd5af4,
      128'h1fdda8338807c731b11210592780ec5f,
      128'h60517fa919b54a0d2de57a9f93c99cef,
      128'ha0e03b4dae2af5b0c8ebbb3c83539961,
      128'h172b047eba77d626e169146355210c7d
   };

   typedef struct packed {
      logic [63:0] block_high;
      logic [63:0] block_low;
      logic        first_block;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       first_round;
      logic       round;
      logic       last_round;
      logic [3:0] round_index;
      logic       finish;
      logic       key_start;
      logic       key_step;
      logic [3:0] key_index;
   } aescbc_cmd_type;

   function automatic logic [7:0] xt(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      logic [7:0] t;
      p = 8'h00;
      t = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ t;
         t = xt(t);
      end
      return p;
   endfunction

   function automatic logic [7:0] sbox(input logic [7:0] x);
      return SBOX_FWD_BITS[11'd2047 - {x, 3'b000} -: 8];
   endfunction

   function automatic logic [7:0] sbox_inverse(input logic [7:0] y);
      return SBOX_INV_BITS[11'd2047 - {y, 3'b000} -: 8];
   endfunction

   function automatic logic [7:0] rcon(input logic [3:0] r);
      logic [7:0] v;
      unique case (r)
         4'd1: v = 8'h01;
         4'd2: v = 8'h02;
         4'd3: v = 8'h04;
         4'd4: v = 8'h08;
         4'd5: v = 8'h10;
         4'd6: v = 8'h20;
         4'd7: v = 8'h40;
         4'd8: v = 8'h80;
         4'd9: v = 8'h1b;
         4'd10: v = 8'h36;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
      return s[127-8*i -: 8];
   endfunction

   function automatic logic [127:0] enc_round(input logic [127:0] s,
                                              input logic mix);
      logic [127:0] t;
      logic [127:0] o;
      logic [7:0]   a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127-8*(4*c+r) -: 8] = sbox(get_byte(s, 4*((c+r)%4)+r));
         end
      end
      o = t;
      if (mix) begin
         for (int c = 0; c < 4; c++) begin
            a0 = get_byte(t, 4*c);
            a1 = get_byte(t, 4*c+1);
            a2 = get_byte(t, 4*c+2);
            a3 = get_byte(t, 4*c+3);
            o[127-8*(4*c)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            o[127-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            o[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            o[127-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
         end
      end
      return o;
   endfunction

   function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
      logic [127:0] t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127-8*(4*c+r) -: 8] = sbox_inverse(get_byte(s, 4*((c-r+4)%4)+r));
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] inv_mix(input logic [127:0] s);
      logic [127:0] o;
      logic [7:0]   a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, 4*c);
         a1 = get_byte(s, 4*c+1);
         a2 = get_byte(s, 4*c+2);
         a3 = get_byte(s, 4*c+3);
         o[127-8*(4*c)   -: 8] = gmul(a0, 8'h0e) ^ gmul(a1, 8'h0b) ^ gmul(a2, 8'h0d)
            ^ gmul(a3, 8'h09);
         o[127-8*(4*c+1) -: 8] = gmul(a0, 8'h09) ^ gmul(a1, 8'h0e) ^ gmul(a2, 8'h0b)
            ^ gmul(a3, 8'h0d);
         o[127-8*(4*c+2) -: 8] = gmul(a0, 8'h0d) ^ gmul(a1, 8'h09) ^ gmul(a2, 8'h0e)
            ^ gmul(a3, 8'h0b);
         o[127-8*(4*c+3) -: 8] = gmul(a0, 8'h0b) ^ gmul(a1, 8'h0d) ^ gmul(a2, 8'h09)
            ^ gmul(a3, 8'h0e);
      end
      return o;
   endfunction

   function automatic logic [127:0] next_key(input logic [127:0] k,
                                             input logic [3:0] r);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      t  = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]),
            sbox(w3[31:24])};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/aescbc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 CBC controller
// Sequences key expansion and the rounds of one request at a time.
// ----------------------------------------------------------------------------
module aescbc_ctrl
   import aescbc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           key_write,
   input  wire logic           direction,
   input  wire logic           req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output aescbc_cmd_type      cmd
);

   typedef enum logic [4:0] {
      ST_KEYS  = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_FIRST = 5'b00100,
      ST_ROUND = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] count_ff, count_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       key_pend_ff, key_pend_in;

   assign req_ready = (state_ff == ST_IDLE) && !key_pend_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      key_pend_in  = key_pend_ff || key_write;
      cmd          = '0;
      cmd.round_index = direction ? 4'(10 - count_ff) : count_ff;
      cmd.key_index   = count_ff;
      unique case (state_ff)
         ST_KEYS: begin
            cmd.key_step = 1'b1;
            count_in = count_ff + 4'd1;
            if (count_ff == 4'd10) begin
               state_in = ST_IDLE;
               count_in = 4'd0;
            end
         end
         ST_IDLE: begin
            if (key_pend_ff) begin
               cmd.key_start = 1'b1;
               key_pend_in   = key_write;
               state_in      = ST_KEYS;
               count_in      = 4'd1;
            end else if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_FIRST;
               count_in = 4'd0;
            end
         end
         ST_FIRST: begin
            cmd.first_round = 1'b1;
            state_in = ST_ROUND;
            count_in = 4'd1;
         end
         ST_ROUND: begin
            cmd.round      = 1'b1;
            cmd.last_round = (count_ff == 4'd10);
            count_in = count_ff + 4'd1;
            if (count_ff == 4'd10) begin
               state_in = ST_DONE;
               count_in = 4'd0;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               count_in     = 4'd0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= 4'd0;
         rsp_valid_ff <= 1'b0;
         key_pend_ff  <= 1'b1;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         key_pend_ff  <= key_pend_in;
      end
   end

`ifndef ASSERT_OFF
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE)
      else $error("request taken outside idle");
   a_finish_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("finished block not presented");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 4'd10)
      else $error("round counter out of range");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/aescbc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 CBC datapath
// State register, one shared round unit, round key registers and chain value.
// ----------------------------------------------------------------------------
module aescbc_datapath
   import aescbc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic [127:0]    key,
   input  wire logic [127:0]    iv,
   input  wire logic            direction,
   input  wire req_payload_type req_payload,
   input  wire aescbc_cmd_type  cmd,
   output rsp_payload_type      rsp_payload
);

   logic [127:0] rk_ff [11];
   logic [127:0] kgen_ff, kgen_in;
   logic [127:0] state_ff, state_in;
   logic [127:0] chain_ff, chain_in;
   logic [127:0] cin_ff, cin_in;
   logic [127:0] out_ff;
   logic [127:0] blk;
   logic [127:0] chain_use;
   logic [127:0] rk;
   logic [127:0] t;

   assign blk       = {req_payload.block_high, req_payload.block_low};
   assign chain_use = req_payload.first_block ? iv : chain_ff;
   assign rk        = rk_ff[cmd.round_index];
   assign kgen_in   = cmd.key_start ? key : next_key(kgen_ff, cmd.key_index);

   always_comb begin
      state_in = state_ff;
      chain_in = chain_ff;
      cin_in   = cin_ff;
      t        = '0;
      if (cmd.load) begin
         cin_in   = chain_use;
         chain_in = direction ? blk : chain_ff;
         state_in = direction ? blk : (blk ^ chain_use);
      end else if (cmd.first_round) begin
         state_in = state_ff ^ rk;
      end else if (cmd.round) begin
         if (direction) begin
            t = inv_sub_shift(state_ff) ^ rk;
            state_in = cmd.last_round ? t : inv_mix(t);
         end else begin
            state_in = enc_round(state_ff, !cmd.last_round) ^ rk;
         end
      end else if (cmd.finish) begin
         state_in = direction ? (state_ff ^ cin_ff) : state_ff;
         if (!direction) chain_in = state_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= '0;
      end else begin
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      cin_ff   <= cin_in;
      if (cmd.finish) out_ff <= state_in;
      if (cmd.key_start || cmd.key_step) begin
         kgen_ff <= kgen_in;
         rk_ff[cmd.key_start ? 4'd0 : cmd.key_index] <= kgen_in;
      end
   end

   assign rsp_payload.result_high = out_ff[127:64];
   assign rsp_payload.result_low  = out_ff[63:0];

`ifndef ASSERT_OFF
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.first_round, cmd.round, cmd.finish, cmd.key_step,
                cmd.key_start}))
      else $error("conflicting datapath commands");
   a_chain_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.load && !cmd.finish |=> $stable(chain_ff))
      else $error("chain value changed outside a block");
   a_key_then_step: assert property (@(posedge clock) disable iff (reset)
      cmd.key_start |=> cmd.key_step)
      else $error("key expansion did not proceed");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/aes128_cbc_cipher_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 CBC cipher core
// One 128-bit block per request, encrypt or decrypt with CBC chaining.
// ----------------------------------------------------------------------------
// A response is valid after the initial key addition, ten rounds in one shared
// round unit, and one finishing step, which waits while the previous response
// is still unaccepted; the controller is idle again as the response appears, so
// the next request can be accepted while the response is presented. A new
// block is taken only after the previous one has finished. After reset and
// after any key write the round keys are expanded, one round key per cycle,
// before the next request is accepted. The response register lets a new block
// start while the previous response still waits.
module aes128_cbc_cipher_core
   import aescbc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire req_payload_type          req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output rsp_payload_type               rsp_payload,
   input  wire logic                     csr_write,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_data
);

   logic [63:0]    key_high_ff, key_low_ff, iv_high_ff, iv_low_ff;
   logic           direction_ff;
   logic           key_write;
   aescbc_cmd_type cmd;

   assign key_write = csr_write && (csr_index == CSR_KEY_HIGH || csr_index == CSR_KEY_LOW);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff  <= '0;
         key_low_ff   <= '0;
         iv_high_ff   <= '0;
         iv_low_ff    <= '0;
         direction_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_KEY_HIGH:  key_high_ff  <= csr_data;
            CSR_KEY_LOW:   key_low_ff   <= csr_data;
            CSR_IV_HIGH:   iv_high_ff   <= csr_data;
            CSR_IV_LOW:    iv_low_ff    <= csr_data;
            CSR_DIRECTION: direction_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   aescbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .key_write (key_write),
      .direction (direction_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   aescbc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .key         ({key_high_ff, key_low_ff}),
      .iv          ({iv_high_ff, iv_low_ff}),
      .direction   (direction_ff),
      .req_payload (req_payload),
      .cmd         (cmd),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

// File: tb/sv/aescbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 CBC checker
// Watches the request, response and register ports of the cipher core, keeps
// its own key schedule and chain value, and compares every response with the
// block it predicts for the oldest outstanding request.
// ----------------------------------------------------------------------------
module aescbc_checker
   import aescbc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_ready,
   input  wire req_payload_type          req_payload,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire rsp_payload_type          rsp_payload,
   input  wire logic                     csr_write,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_data,
   output int                            failures,
   output int                            pending
);

   logic [7:0] fwd_sub [256];
   logic [7:0] inv_sub [256];
   logic [63:0] key_hi, key_lo, iv_hi, iv_lo;
   logic        decrypting;
   logic [127:0] chain_value;
   logic [127:0] round_keys [11];
   rsp_payload_type expected_blocks [$];

   function automatic logic [7:0] mul2(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = mul2(a);
      end
      return p;
   endfunction

   // The substitution tables are built from the field inverse and affine map.
   task automatic build_sub_tables();
      logic [7:0] inv, s;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h00;
         for (int y = 1; y < 256; y++) begin
            if (gf_product(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
         end
         s = 8'h63;
         for (int i = 0; i < 8; i++) begin
            s[i] = s[i] ^ inv[i] ^ inv[(i + 4) % 8] ^ inv[(i + 5) % 8]
               ^ inv[(i + 6) % 8] ^ inv[(i + 7) % 8];
         end
         fwd_sub[x] = s;
         inv_sub[s] = x[7:0];
      end
   endtask

   task automatic expand_schedule();
      logic [31:0] w [44];
      logic [31:0] t;
      logic [7:0]  rc;
      logic [127:0] k;
      k = {key_hi, key_lo};
      for (int i = 0; i < 4; i++) w[i] = k[127 - 32 * i -: 32];
      rc = 8'h01;
      for (int i = 4; i < 44; i++) begin
         t = w[i - 1];
         if (i % 4 == 0) begin
            t = {fwd_sub[t[23:16]] ^ rc, fwd_sub[t[15:8]], fwd_sub[t[7:0]],
                 fwd_sub[t[31:24]]};
            rc = mul2(rc);
         end
         w[i] = w[i - 4] ^ t;
      end
      for (int r = 0; r < 11; r++) begin
         round_keys[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
      end
   endtask

   function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
      return s[127 - 8 * i -: 8];
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] s, input bit inverse);
      logic [7:0] m [4];
      logic [7:0] v;
      logic [127:0] o;
      if (inverse) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
      else m = '{8'h02, 8'h03, 8'h01, 8'h01};
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            v = 8'h00;
            for (int j = 0; j < 4; j++) begin
               v ^= gf_product(m[(j - r + 4) % 4], byte_at(s, 4 * c + j));
            end
            o[127 - 8 * (4 * c + r) -: 8] = v;
         end
      end
      return o;
   endfunction

   function automatic logic [127:0] sub_shift(input logic [127:0] s, input bit inverse);
      logic [127:0] o;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (inverse) begin
               o[127 - 8 * (4 * c + r) -: 8] = inv_sub[byte_at(s, 4 * ((c - r + 4) % 4) + r)];
            end else begin
               o[127 - 8 * (4 * c + r) -: 8] = fwd_sub[byte_at(s, 4 * ((c + r) % 4) + r)];
            end
         end
      end
      return o;
   endfunction

   function automatic logic [127:0] encrypt_block(input logic [127:0] s);
      s ^= round_keys[0];
      for (int r = 1; r <= 10; r++) begin
         s = sub_shift(s, 1'b0);
         if (r != 10) s = mix_columns(s, 1'b0);
         s ^= round_keys[r];
      end
      return s;
   endfunction

   function automatic logic [127:0] decrypt_block(input logic [127:0] s);
      s ^= round_keys[10];
      for (int r = 9; r >= 0; r--) begin
         s = sub_shift(s, 1'b1);
         s ^= round_keys[r];
         if (r != 0) s = mix_columns(s, 1'b1);
      end
      return s;
   endfunction

   initial begin
      build_sub_tables();
   end

   always @(posedge clock) begin
      logic [127:0] data_in, data_out;
      rsp_payload_type exp_rsp;
      rsp_payload_type new_rsp;
      if (reset) begin
         key_hi = '0;
         key_lo = '0;
         iv_hi = '0;
         iv_lo = '0;
         decrypting = 1'b0;
         chain_value = '0;
         expected_blocks.delete();
         failures <= 0;
         pending <= 0;
         expand_schedule();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_KEY_HIGH: begin
                  key_hi = csr_data;
                  expand_schedule();
               end
               CSR_KEY_LOW: begin
                  key_lo = csr_data;
                  expand_schedule();
               end
               CSR_IV_HIGH: iv_hi = csr_data;
               CSR_IV_LOW: iv_lo = csr_data;
               CSR_DIRECTION: decrypting = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            data_in = {req_payload.block_high, req_payload.block_low};
            if (req_payload.first_block) chain_value = {iv_hi, iv_lo};
            if (!decrypting) begin
               data_out = encrypt_block(data_in ^ chain_value);
               chain_value = data_out;
            end else begin
               data_out = decrypt_block(data_in) ^ chain_value;
               chain_value = data_in;
            end
            new_rsp.result_high = data_out[127:64];
            new_rsp.result_low = data_out[63:0];
            expected_blocks.insert(expected_blocks.size(), new_rsp);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_blocks.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h", $time,
                        rsp_payload);
               failures <= failures + 1;
            end else begin
               exp_rsp = expected_blocks.pop_front();
               if (rsp_payload.result_high !== exp_rsp.result_high
                   || rsp_payload.result_low !== exp_rsp.result_low) begin
                  $display("%0t: response mismatch, expected %h_%h, actual %h_%h", $time,
                           exp_rsp.result_high, exp_rsp.result_low,
                           rsp_payload.result_high, rsp_payload.result_low);
                  failures <= failures + 1;
               end
            end
         end
         pending <= expected_blocks.size();
      end
   end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 CBC core testbench
// Drives directed and random blocks through the cipher core in both directions
// under several key, IV and flow-control settings; the checker predicts and
// compares every response.
// ----------------------------------------------------------------------------
module tb_top;
   import aescbc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_write = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0] csr_data = '0;
   int failures;
   int pending;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off_cycles = 0;
   int cycle_count = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   aes128_cbc_cipher_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   aescbc_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .failures(failures), .pending(pending)
   );

   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   function automatic logic [63:0] random_word();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(7))
         0: w = '0;
         1: w = '1;
         default: ;
      endcase
      return w;
   endfunction

   task automatic write_register(input logic [CsrIndexWidth-1:0] index,
                                 input logic [63:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
   endtask

   task automatic send_request(input logic [63:0] high, input logic [63:0] low,
                               input logic first);
      csr_write <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{block_high: high, block_low: low, first_block: first};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      csr_write <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic random_setup(input bit decrypt);
      write_register(CSR_KEY_HIGH, random_word());
      write_register(CSR_KEY_LOW, random_word());
      write_register(CSR_IV_HIGH, random_word());
      write_register(CSR_IV_LOW, random_word());
      write_register(CSR_DIRECTION, {63'd0, decrypt});
   endtask

   task automatic random_chains(input int count);
      for (int i = 0; i < count; i++) begin
         send_request(random_word(), random_word(), (i == 0) || ($urandom_range(7) == 0));
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_request('0, '0, 1'b0);
      send_request('1, '1, 1'b0);
      send_request(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
      drain();
      write_register(CSR_KEY_HIGH, 64'h0001020304050607);
      write_register(CSR_KEY_LOW, 64'h08090a0b0c0d0e0f);
      write_register(CSR_IV_HIGH, '1);
      write_register(CSR_IV_LOW, 64'h0123456789abcdef);
      send_request(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
      send_request('1, '0, 1'b0);
      drain();
      write_register(CSR_IV_LOW, '0);
      send_request('0, '1, 1'b0);
      send_request(64'h8000000000000001, 64'h0000000180000000, 1'b1);
      drain();
      write_register(CSR_DIRECTION, 64'd1);
      send_request('1, '1, 1'b0);
      send_request(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1);
      send_request('0, '0, 1'b0);
      drain();
      write_register(CSR_KEY_LOW, '1);
      write_register(3'd7, '1);
      send_request(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0);
      drain();
      write_register(CSR_DIRECTION, 64'd0);
      send_request(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0);
      drain();
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
         endcase
         random_setup(phase[0]);
         if (phase == 4) hold_off_cycles = 300;
         random_chains(140);
         drain();
      end
      if (failures == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
